[rtl/csvt_pkg.sv]
package csvt_pkg;

    localparam int CELL_BYTES = 256;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_PLAIN  = 2'd1;
    localparam logic [1:0] MODE_QUOTED = 2'd2;
    localparam logic [1:0] MODE_QSEEN  = 2'd3;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       kind;
        logic [7:0] char_out;
        logic [7:0] position;
        logic [7:0] trimmed_length;
        logic [7:0] column;
        logic       line_end;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] raw_count;
        logic [7:0] out_pos;
        logic [7:0] trimmed_len;
        logic       seen_content;
        logic [7:0] column_index;
    } state_t;

    typedef struct packed {
        logic [QUEUE_AW:0] count;
        logic              room_for_two;
    } queue_status_t;

    function automatic logic is_space(logic [7:0] b);
        is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic ends_line(logic [7:0] b);
        ends_line = (b == CH_NUL) || (b == CH_CR) || (b == CH_LF);
    endfunction

endpackage

[rtl/csvt_byte_if.sv]
interface csvt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/csvt_result_if.sv]
interface csvt_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_out;
    logic [7:0] position;
    logic [7:0] trimmed_length;
    logic [7:0] column;
    logic       line_end;
    logic       last;

    modport source (output valid, output kind, output char_out, output position,
                    output trimmed_length, output column, output line_end,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_out, input position,
                    input trimmed_length, input column, input line_end,
                    input last, output ready);
endinterface

[rtl/csvt_step.sv]
module csvt_step (
    input  csvt_pkg::state_t  state,
    input  logic [7:0]        data_byte,
    output csvt_pkg::state_t  state_next,
    output logic              emit0,
    output logic              emit1,
    output csvt_pkg::result_t res0,
    output csvt_pkg::result_t res1
);
    import csvt_pkg::*;

    typedef struct packed {
        state_t  st;
        logic    emit;
        result_t res;
    } act_t;

    function automatic act_t no_action(state_t s);
        act_t a;
        a.st   = s;
        a.emit = 1'b0;
        a.res  = '0;
        no_action = a;
    endfunction

    // Keep a raw byte if the cell has room; emit it unless it is leading whitespace.
    function automatic act_t do_content(state_t s, logic [7:0] b);
        act_t       a;
        logic [8:0] raw_inc;
        a       = no_action(s);
        raw_inc = {1'b0, s.raw_count} + 9'd1;
        if (raw_inc < 9'(CELL_BYTES))
        begin
            a.st.raw_count = raw_inc[7:0];
            if (s.seen_content || !is_space(b))
            begin
                a.st.seen_content = 1'b1;
                a.emit            = 1'b1;
                a.res.kind        = KIND_CHAR;
                a.res.char_out    = b;
                a.res.position    = s.out_pos;
                a.res.column      = s.column_index;
                a.st.out_pos      = s.out_pos + 8'd1;
                if (!is_space(b))
                begin
                    a.st.trimmed_len = s.out_pos + 8'd1;
                end
            end
        end
        do_content = a;
    endfunction

    // Close the cell and clear the per-cell counters.
    function automatic act_t do_end(state_t s, logic lend);
        act_t a;
        a                    = no_action(s);
        a.emit               = 1'b1;
        a.res.kind           = KIND_END;
        a.res.trimmed_length = s.trimmed_len;
        a.res.column         = s.column_index;
        a.res.line_end       = lend;
        a.st.raw_count       = '0;
        a.st.out_pos         = '0;
        a.st.trimmed_len     = '0;
        a.st.seen_content    = 1'b0;
        a.st.mode            = MODE_START;
        if (lend)
        begin
            a.st.column_index = '0;
        end
        else if (s.column_index != 8'hFF)
        begin
            a.st.column_index = s.column_index + 8'd1;
        end
        do_end = a;
    endfunction

    act_t   a0;
    act_t   a1;
    state_t s_tmp;

    always_comb
    begin
        a0    = no_action(state);
        a1    = no_action(state);
        s_tmp = state;
        case (state.mode)
            MODE_START:
            begin
                if (data_byte == CH_QUOTE)
                begin
                    a0.st.mode = MODE_QUOTED;
                end
                else if (data_byte == CH_COMMA)
                begin
                    a0 = do_end(state, 1'b0);
                end
                else if (ends_line(data_byte))
                begin
                    a0 = do_end(state, 1'b1);
                end
                else
                begin
                    s_tmp.mode = MODE_PLAIN;
                    a0 = do_content(s_tmp, data_byte);
                end
                a1 = no_action(a0.st);
            end
            MODE_PLAIN:
            begin
                if (data_byte == CH_COMMA)
                begin
                    a0 = do_end(state, 1'b0);
                end
                else if (ends_line(data_byte))
                begin
                    a0 = do_end(state, 1'b1);
                end
                else
                begin
                    a0 = do_content(state, data_byte);
                end
                a1 = no_action(a0.st);
            end
            MODE_QUOTED:
            begin
                if (data_byte == CH_QUOTE)
                begin
                    a0.st.mode = MODE_QSEEN;
                end
                else if (data_byte == CH_NUL)
                begin
                    a0 = do_end(state, 1'b1);
                end
                else
                begin
                    a0 = do_content(state, data_byte);
                end
                a1 = no_action(a0.st);
            end
            default:
            begin
                if (data_byte == CH_QUOTE)
                begin
                    s_tmp.mode = MODE_QUOTED;
                    a0 = do_content(s_tmp, data_byte);
                    a1 = no_action(a0.st);
                end
                else if (data_byte == CH_COMMA)
                begin
                    a0 = do_end(state, 1'b0);
                    a1 = no_action(a0.st);
                end
                else if (ends_line(data_byte))
                begin
                    a0 = do_end(state, 1'b1);
                    a1 = no_action(a0.st);
                end
                else
                begin
                    // Byte after a closing quote: end the cell, then start a plain one.
                    a0         = do_end(state, 1'b0);
                    s_tmp      = a0.st;
                    s_tmp.mode = MODE_PLAIN;
                    a1         = do_content(s_tmp, data_byte);
                end
            end
        endcase
    end

    always_comb
    begin
        state_next = a1.st;
        emit0      = a0.emit;
        emit1      = a1.emit;
        res0       = a0.res;
        res0.last  = !a1.emit;
        res1       = a1.res;
        res1.last  = 1'b1;
    end

endmodule

[rtl/csvt_out_queue.sv]
module csvt_out_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push0,
    input  logic                    push1,
    input  csvt_pkg::result_t       data0,
    input  csvt_pkg::result_t       data1,
    output csvt_pkg::queue_status_t status,
    csvt_result_if.source           tokens
);
    import csvt_pkg::*;

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                pop;
    logic [QUEUE_AW-1:0] wr_ptr_plus1;
    logic [QUEUE_AW:0]   push_num;
    result_t             head;

    assign pop          = tokens.valid && tokens.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign push_num     = (QUEUE_AW + 1)'(push0) + (QUEUE_AW + 1)'(push1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_num[QUEUE_AW-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + push_num - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_reg[wr_ptr_reg] <= data0;
        end
        if (push1)
        begin
            entry_reg[wr_ptr_plus1] <= data1;
        end
    end

    assign head = entry_reg[rd_ptr_reg];

    assign status.count        = count_reg;
    assign status.room_for_two = (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

    assign tokens.valid          = (count_reg != '0);
    assign tokens.kind           = head.kind;
    assign tokens.char_out       = head.char_out;
    assign tokens.position       = head.position;
    assign tokens.trimmed_length = head.trimmed_length;
    assign tokens.column         = head.column;
    assign tokens.line_end       = head.line_end;
    assign tokens.last           = head.last;

endmodule

[rtl/csv_cell_tokenizer_core.sv]
// A byte accepted into the input register is parsed and written to the result queue once
//   the queue has room for both possible results; its first result can then be taken.
// Throughput: one byte per cycle while at most two results wait in the four-entry queue;
//   hold the input register when more are waiting. A byte that gives two results (cell end
//   plus content after a closing quote) leaves them in turn on the single result port.
// Reset (rst_n, async, active low): parser returns to cell start at column 0, queue empties.
module csv_cell_tokenizer_core (
    input  logic          clk,
    input  logic          rst_n,
    csvt_byte_if.sink     text,
    csvt_result_if.source tokens
);
    import csvt_pkg::*;

    // Input register: one byte waiting for the parser.
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;

    // Parser state across bytes.
    state_t        state_reg;
    state_t        state_next;

    logic          emit0;
    logic          emit1;
    result_t       res0;
    result_t       res1;
    logic          advance;
    queue_status_t q_status;

    // Advance the held byte only when the queue can take both of its possible results.
    assign advance    = in_valid_reg && q_status.room_for_two;
    assign text.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    // Payload register: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{mode: MODE_START, raw_count: 8'd0, out_pos: 8'd0,
                           trimmed_len: 8'd0, seen_content: 1'b0, column_index: 8'd0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Per-byte parse: quoting modes, cell limits, trim tracking, column count.
    csvt_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .state_next (state_next),
        .emit0      (emit0),
        .emit1      (emit1),
        .res0       (res0),
        .res1       (res1)
    );

    // Result queue decouples parsing from a stalled consumer.
    csvt_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push0  (advance && emit0),
        .push1  (advance && emit1),
        .data0  (res0),
        .data1  (res1),
        .status (q_status),
        .tokens (tokens)
    );

    // A second result only ever follows a first one from the same byte.
    assert property (@(posedge clk) disable iff (!rst_n) emit1 |-> emit0)
        else $error("second result without first");

    // Queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // At cell start no per-cell counts remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_START) |-> (state_reg.raw_count == 8'd0 &&
            state_reg.out_pos == 8'd0 && !state_reg.seen_content))
        else $error("stale cell counters at cell start");

    // Trimmed length never runs past the emitted length.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.trimmed_len <= state_reg.out_pos)
        else $error("trimmed length exceeds cell length");

endmodule
